[sv/wtdl_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Water table depth locator package
// Shared types, widths and constants of the water table depth locator.
// ---------------------------------------------------------------------------
package wtdl_pkg;

   localparam int DEFAULT_MAX_LAYERS = 64;
   localparam int QUEUE_DEPTH        = 2;

   localparam int PRES_W   = 32;
   localparam int THK_W    = 24;
   localparam int DZ_W     = THK_W + 1;
   localparam int DEPTH_W  = 30;
   localparam int STATUS_W = 2;
   localparam int PROD_W   = (PRES_W - 1) + DZ_W;
   localparam int DEN_W    = PRES_W + 1;
   localparam int QUO_W    = PROD_W - (DEN_W - 1);

   localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_REG_SEARCH_FROM_TOP = 1'b0;

   localparam logic [STATUS_W-1:0] STATUS_CROSSING = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNSAT    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SAT      = 2'd2;

   typedef struct packed {
      logic signed [PRES_W-1:0] layer_pressure;
      logic [THK_W-1:0]         layer_thickness;
      logic                     last_layer;
   } req_item_type;

   typedef struct packed {
      logic [DEPTH_W-1:0]  table_depth;
      logic [STATUS_W-1:0] table_status;
   } rsp_item_type;

   typedef enum logic {
      ITEM_LOAD,
      ITEM_LOAD_EVAL
   } item_kind_type;

   typedef struct packed {
      item_kind_type            kind;
      logic signed [PRES_W-1:0] pressure;
      logic [THK_W-1:0]         thickness;
   } queue_entry_type;

   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } queue_out_type;

   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] dividend;
      logic [DEN_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_READ,
      B_CHECK,
      B_MUL,
      B_DIV_GO,
      B_DIV_WAIT,
      B_OUT
   } back_state_type;

endpackage
`default_nettype wire

[sv/wtdl_ram.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module wtdl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

[sv/wtdl_front.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Water table depth locator front end
// Accepts layer items, tags them as load or load-and-evaluate and queues
// them for the back end.
// ---------------------------------------------------------------------------
module wtdl_front
   import wtdl_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_item_type req_item,
   output queue_out_type     q_out,
   input  wire logic         q_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   queue_entry_type  entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;
   queue_entry_type  new_entry;

   always_comb begin
      req_stall = (count_ff == CNT_W'(QUEUE_DEPTH));
      push      = req_valid && !req_stall;
      pop       = q_pop && (count_ff != '0);

      new_entry.kind      = req_item.last_layer ? ITEM_LOAD_EVAL : ITEM_LOAD;
      new_entry.pressure  = req_item.layer_pressure;
      new_entry.thickness = req_item.layer_thickness;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end

      q_out.valid = (count_ff != '0);
      q_out.entry = entries_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule
`default_nettype wire

[sv/wtdl_div.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Water table depth locator divider
// Restoring divider producing one quotient bit per cycle. The dividend is
// known to give a quotient that fits the quotient width.
// ---------------------------------------------------------------------------
module wtdl_div
   import wtdl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   localparam int STEP_W = $clog2(QUO_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  divisor_ff, divisor_in;
   logic [QUO_W-1:0]  low_ff, low_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    diff;
   logic              fits;

   always_comb begin
      trial = {rem_ff, low_ff[QUO_W-1]};
      diff  = trial - {1'b0, divisor_ff};
      fits  = (trial >= {1'b0, divisor_ff});

      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      low_in     = low_ff;
      quo_in     = quo_ff;

      if (div_req.start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         rem_in     = {1'b0, div_req.dividend[PROD_W-1:QUO_W]};
         low_in     = div_req.dividend[QUO_W-1:0];
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         low_in  = {low_ff[QUO_W-2:0], 1'b0};
         quo_in  = {quo_ff[QUO_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end

      div_rsp.done     = done_ff;
      div_rsp.quotient = quo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      low_ff     <= low_in;
      quo_ff     <= quo_in;
   end

endmodule
`default_nettype wire

[sv/wtdl_back.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Water table depth locator back end
// Stores the layers of a column, walks the stored column for the sign change
// of pressure, interpolates the crossing depth and drives the result item.
// ---------------------------------------------------------------------------
module wtdl_back
   import wtdl_pkg::*;
#(
   parameter int MAX_LAYERS = DEFAULT_MAX_LAYERS
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          search_from_top,
   input  wire queue_out_type q_out,
   output logic               q_pop,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output rsp_item_type       rsp_item
);

   localparam int ADDR_W = $clog2(MAX_LAYERS);
   localparam int CNT_W  = $clog2(MAX_LAYERS + 1);
   localparam int SUM_W  = THK_W + CNT_W;
   localparam int WORD_W = PRES_W + THK_W + SUM_W;
   localparam int POS_W  = SUM_W + 1;
   localparam int EXT_W  = (POS_W > DEPTH_W) ? POS_W : DEPTH_W;
   localparam logic [ADDR_W-1:0] MAX_IDX = ADDR_W'(MAX_LAYERS - 1);

   back_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SUM_W-1:0]  total_ff, total_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] end_ff, end_in;
   logic              first_ff, first_in;
   logic [WORD_W-1:0] prev_ff, prev_in;
   logic [WORD_W-1:0] sat_ff, sat_in;
   logic [WORD_W-1:0] unsat_ff, unsat_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_item_ff, rsp_item_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [WORD_W-1:0] ram_wdata;
   logic [ADDR_W-1:0] ram_raddr;
   logic [WORD_W-1:0] ram_rdata;

   div_req_type       div_req;
   div_rsp_type       div_rsp;

   logic              stored;
   logic [ADDR_W-1:0] last_idx;
   logic              neg;
   logic              at_end;
   logic [ADDR_W-1:0] next_addr;
   logic signed [PRES_W-1:0] sat_p;
   logic signed [PRES_W-1:0] unsat_p;
   logic [THK_W-1:0]  sat_dz;
   logic [THK_W-1:0]  unsat_dz;
   logic [DZ_W-1:0]   dz_sum;
   logic [DEN_W-1:0]  den_diff;
   logic [POS_W-1:0]  corr_ext;
   logic [POS_W-1:0]  pos_diff;

   function automatic logic [DEPTH_W-1:0] clamp_depth(input logic [EXT_W-1:0] v);
      logic [DEPTH_W-1:0] r;
      r = (v > EXT_W'(DEPTH_MAX)) ? DEPTH_MAX : v[DEPTH_W-1:0];
      return r;
   endfunction

   wtdl_ram #(
      .WIDTH(WORD_W),
      .DEPTH(MAX_LAYERS)
   ) u_layer_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   wtdl_div u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      addr_in      = addr_ff;
      end_in       = end_ff;
      first_in     = first_ff;
      prev_in      = prev_ff;
      sat_in       = sat_ff;
      unsat_in     = unsat_ff;
      prod_in      = prod_ff;
      den_in       = den_ff;
      pos_in       = pos_ff;
      depth_in     = depth_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;

      q_pop     = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = count_ff[ADDR_W-1:0];
      ram_wdata = {q_out.entry.pressure, q_out.entry.thickness, total_ff};
      ram_raddr = addr_ff;

      div_req.start    = 1'b0;
      div_req.dividend = prod_ff;
      div_req.divisor  = den_ff;

      stored    = (count_ff < CNT_W'(MAX_LAYERS));
      last_idx  = stored ? count_ff[ADDR_W-1:0] : MAX_IDX;
      neg       = ram_rdata[WORD_W-1];
      at_end    = search_from_top ? (addr_ff == end_ff) : (addr_ff == '0);
      next_addr = search_from_top ? addr_ff + 1'b1 : addr_ff - 1'b1;

      sat_p    = sat_ff[WORD_W-1 -: PRES_W];
      unsat_p  = unsat_ff[WORD_W-1 -: PRES_W];
      sat_dz   = sat_ff[SUM_W +: THK_W];
      unsat_dz = unsat_ff[SUM_W +: THK_W];
      dz_sum   = DZ_W'(sat_dz) + DZ_W'(unsat_dz);
      den_diff = {1'b0, sat_p} - {unsat_p[PRES_W-1], unsat_p};
      corr_ext = POS_W'(div_rsp.quotient);
      pos_diff = pos_ff - corr_ext;

      unique case (state_ff)
         B_IDLE: begin
            if (q_out.valid) begin
               q_pop = 1'b1;
               if (stored) begin
                  ram_we   = 1'b1;
                  count_in = count_ff + 1'b1;
                  total_in = total_ff + SUM_W'(q_out.entry.thickness);
               end
               if (q_out.entry.kind == ITEM_LOAD_EVAL) begin
                  end_in   = last_idx;
                  addr_in  = search_from_top ? '0 : last_idx;
                  state_in = B_READ;
               end
            end
         end
         B_READ: begin
            first_in = 1'b1;
            state_in = B_CHECK;
         end
         B_CHECK: begin
            if (!search_from_top && neg && first_ff) begin
               depth_in  = clamp_depth(EXT_W'(total_ff));
               status_in = STATUS_UNSAT;
               state_in  = B_OUT;
            end else if (search_from_top && !neg && first_ff) begin
               depth_in  = '0;
               status_in = STATUS_SAT;
               state_in  = B_OUT;
            end else if ((!search_from_top && neg) || (search_from_top && !neg)) begin
               sat_in   = search_from_top ? ram_rdata : prev_ff;
               unsat_in = search_from_top ? prev_ff : ram_rdata;
               state_in = B_MUL;
            end else if (at_end) begin
               depth_in  = search_from_top ? clamp_depth(EXT_W'(total_ff)) : '0;
               status_in = search_from_top ? STATUS_UNSAT : STATUS_SAT;
               state_in  = B_OUT;
            end else begin
               prev_in   = ram_rdata;
               first_in  = 1'b0;
               addr_in   = next_addr;
               ram_raddr = next_addr;
            end
         end
         B_MUL: begin
            prod_in  = sat_p[PRES_W-2:0] * dz_sum;
            den_in   = {den_diff[DEN_W-2:0], 1'b0};
            pos_in   = POS_W'(sat_ff[SUM_W-1:0]) + POS_W'(sat_dz[THK_W-1:1]);
            state_in = B_DIV_GO;
         end
         B_DIV_GO: begin
            div_req.start = 1'b1;
            state_in      = B_DIV_WAIT;
         end
         B_DIV_WAIT: begin
            if (div_rsp.done) begin
               depth_in  = (corr_ext >= pos_ff) ? '0 : clamp_depth(EXT_W'(pos_diff));
               status_in = STATUS_CROSSING;
               state_in  = B_OUT;
            end
         end
         B_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_item_in.table_depth  = depth_ff;
               rsp_item_in.table_status = status_ff;
               count_in                 = '0;
               total_in                 = '0;
               state_in                 = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase

      rsp_valid = rsp_valid_ff;
      rsp_item  = rsp_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      end_ff      <= end_in;
      first_ff    <= first_in;
      prev_ff     <= prev_in;
      sat_ff      <= sat_in;
      unsat_ff    <= unsat_in;
      prod_ff     <= prod_in;
      den_ff      <= den_in;
      pos_ff      <= pos_in;
      depth_ff    <= depth_in;
      status_ff   <= status_in;
      rsp_item_ff <= rsp_item_in;
   end

endmodule
`default_nettype wire

[sv/water_table_depth_locator.sv]
`default_nettype none
// Layer items enter a two-entry queue and are stored one per cycle in the idle back end,
// up to MAX_LAYERS per column. A marked layer holds the back end while it examines
// m <= n layers; a crossing holds it also for the divider, one quotient bit per cycle.
// Later layers wait in the queue; once the result is loaded into the output register
// the back end returns to idle for the next column.
// Synchronous reset clears the control state and the layer count; the memory is not cleared.
// ---------------------------------------------------------------------------
// Water table depth locator
// Top level: configuration register, front end queue and back end search.
// ---------------------------------------------------------------------------
module water_table_depth_locator
   import wtdl_pkg::*;
#(
   parameter int MAX_LAYERS = DEFAULT_MAX_LAYERS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_item_type          req_item,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_item_type               rsp_item,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   logic          search_ff, search_in;
   queue_out_type q_out;
   logic          q_pop;

   always_comb begin
      pready    = 1'b1;
      search_in = search_ff;
      if (psel && penable && pwrite && (paddr[2] == CSR_REG_SEARCH_FROM_TOP)) begin
         search_in = pwdata[0];
      end
      prdata = (paddr[2] == CSR_REG_SEARCH_FROM_TOP) ? CSR_DATA_W'(search_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         search_ff <= 1'b0;
      end else begin
         search_ff <= search_in;
      end
   end

   wtdl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item (req_item),
      .q_out    (q_out),
      .q_pop    (q_pop)
   );

   wtdl_back #(
      .MAX_LAYERS(MAX_LAYERS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .search_from_top(search_ff),
      .q_out          (q_out),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_item       (rsp_item)
   );

endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Water table depth locator testbench
// Sends soil columns, both hand-picked and random, in both search
// directions and under varied sender and receiver idling. A scoreboard
// predicts each column's depth and status and checks every result item.
// ---------------------------------------------------------------------------
module testbench;
   import wtdl_pkg::*;

   localparam int MAX_LAYERS   = DEFAULT_MAX_LAYERS;
   localparam int DRAIN_CYCLES = MAX_LAYERS + 48;

   typedef enum int {
      SHAPE_PROFILE,
      SHAPE_NOISE,
      SHAPE_EXTREME
   } column_shape_type;

   class water_table_scoreboard;
      logic signed [PRES_W-1:0] pressure_mem [MAX_LAYERS];
      logic [THK_W-1:0]         thickness_mem [MAX_LAYERS];
      int                       layers_held;
      bit                       from_top;
      rsp_item_type             depth_queue [$];
      int                       errors;
      int                       layers_seen;
      int                       results_seen;
      int                       status_count [3];

      function int outstanding();
         return depth_queue.size();
      endfunction

      function longint unsigned column_sum(int upto);
         longint unsigned s;
         s = 0;
         for (int l = 0; l < upto; l++) s += thickness_mem[l];
         return s;
      endfunction

      function logic [DEPTH_W-1:0] clamp(longint unsigned d);
         if (d > DEPTH_MAX) return DEPTH_MAX;
         return d[DEPTH_W-1:0];
      endfunction

      function bit is_crossing(int k);
         return pressure_mem[k] >= 0 && pressure_mem[k-1] < 0;
      endfunction

      // Interpolates between the centers of unsaturated layer k-1 and saturated layer k.
      function logic [DEPTH_W-1:0] crossing_depth(int k);
         longint unsigned pk, neg_above, den, dz_pair, corr, pos;
         pk        = longint'(pressure_mem[k]);
         neg_above = -longint'(pressure_mem[k-1]);
         den       = pk + neg_above;
         dz_pair   = longint'(thickness_mem[k-1]) + longint'(thickness_mem[k]);
         corr      = (pk * dz_pair) / (2 * den);
         pos       = column_sum(k) + (thickness_mem[k] >> 1);
         if (corr >= pos) return '0;
         return clamp(pos - corr);
      endfunction

      function rsp_item_type locate_table(int n);
         rsp_item_type r;
         r.table_depth  = '0;
         r.table_status = STATUS_SAT;
         if (!from_top) begin
            if (pressure_mem[n-1] < 0) begin
               r.table_depth  = clamp(column_sum(n));
               r.table_status = STATUS_UNSAT;
               return r;
            end
            for (int k = n - 1; k >= 1; k--) begin
               if (is_crossing(k)) begin
                  r.table_depth  = crossing_depth(k);
                  r.table_status = STATUS_CROSSING;
                  return r;
               end
            end
         end else begin
            if (pressure_mem[0] >= 0) return r;
            for (int k = 1; k < n; k++) begin
               if (is_crossing(k)) begin
                  r.table_depth  = crossing_depth(k);
                  r.table_status = STATUS_CROSSING;
                  return r;
               end
            end
            r.table_depth  = clamp(column_sum(n));
            r.table_status = STATUS_UNSAT;
         end
         return r;
      endfunction

      function void note_layer(req_item_type it);
         rsp_item_type r;
         layers_seen++;
         if (layers_held < MAX_LAYERS) begin
            pressure_mem[layers_held]  = it.layer_pressure;
            thickness_mem[layers_held] = it.layer_thickness;
            layers_held++;
         end
         if (it.last_layer) begin
            r = locate_table(layers_held);
            layers_held = 0;
            status_count[r.table_status]++;
            depth_queue.push_back(r);
         end
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         results_seen++;
         if (depth_queue.size() == 0) begin
            errors++;
            $display("%0t: result item with no column pending, depth %0d status %0d",
                     $time, got.table_depth, got.table_status);
            return;
         end
         want = depth_queue.pop_front();
         if (got.table_depth !== want.table_depth) begin
            errors++;
            $display("%0t: table_depth mismatch, expected %0d, actual %0d",
                     $time, want.table_depth, got.table_depth);
         end
         if (got.table_status !== want.table_status) begin
            errors++;
            $display("%0t: table_status mismatch, expected %0d, actual %0d",
                     $time, want.table_status, got.table_status);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_item_type          req_item = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_item_type          rsp_item;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   water_table_scoreboard sb;
   int idle_pct = 0;
   int stall_pct = 0;
   int hold_off_cycles = 0;
   int items_sent = 0;

   water_table_depth_locator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_layer(req_item);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_item);
      end
   end

   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   task automatic apb_access(input bit write, input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= CSR_ADDR_W'(4 * CSR_REG_SEARCH_FROM_TOP);
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic configure(input bit from_top);
      logic [CSR_DATA_W-1:0] readback;
      apb_access(1'b1, CSR_DATA_W'(from_top), readback);
      apb_access(1'b0, '0, readback);
      if (readback[0] !== from_top) begin
         sb.errors++;
         $display("%0t: search_from_top readback mismatch, expected %0d, actual %0d",
                  $time, from_top, readback[0]);
      end
      sb.from_top = from_top;
   endtask

   task automatic send_layer(input logic signed [PRES_W-1:0] pressure,
                             input logic [THK_W-1:0] thickness, input bit last);
      req_item_type it;
      it.layer_pressure  = pressure;
      it.layer_thickness = thickness;
      it.last_layer      = last;
      while ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic send_column(input int n, input column_shape_type shape);
      int                       cross_at;
      logic signed [PRES_W-1:0] magnitude;
      logic signed [PRES_W-1:0] pressure;
      logic [THK_W-1:0]         thickness;
      cross_at = $urandom_range(0, n);
      for (int i = 0; i < n; i++) begin
         magnitude = PRES_W'($urandom >> $urandom_range(1, 31));
         thickness = THK_W'($urandom >> $urandom_range(8, 31));
         case (shape)
            SHAPE_PROFILE: pressure = (i < cross_at) ? ~magnitude : magnitude;
            SHAPE_NOISE:   pressure = $urandom;
            default: begin
               case ($urandom_range(0, 3))
                  0:       pressure = 32'sh8000_0000;
                  1:       pressure = -1;
                  2:       pressure = 0;
                  default: pressure = 32'sh7FFF_FFFF;
               endcase
               thickness = $urandom_range(0, 1) ? '1 : '0;
            end
         endcase
         send_layer(pressure, thickness, i == n - 1);
      end
   endtask

   task automatic send_random_column();
      int n;
      int pick;
      column_shape_type shape;
      pick = $urandom_range(0, 99);
      if (pick < 88) n = $urandom_range(1, 8);
      else if (pick < 99) n = $urandom_range(9, 40);
      else n = $urandom_range(MAX_LAYERS + 1, MAX_LAYERS + 6);
      pick = $urandom_range(0, 99);
      if (pick < 60) shape = SHAPE_PROFILE;
      else if (pick < 85) shape = SHAPE_NOISE;
      else shape = SHAPE_EXTREME;
      send_column(n, shape);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   task automatic settle();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input bit from_top, input int idle, input int stall,
                            input int items);
      int target;
      configure(from_top);
      idle_pct  = idle;
      stall_pct = stall;
      target    = items_sent + items;
      while (items_sent < target) send_random_column();
      settle();
   endtask

   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int dir = 0; dir < 2; dir++) begin
         configure(dir[0]);
         send_layer(-1, '1, 1'b1);
         send_layer(0, '0, 1'b1);
         send_layer(32'sh8000_0000, '1, 1'b0);
         send_layer(32'sh7FFF_FFFF, '1, 1'b1);
         send_layer(-1, 24'h000100, 1'b0);
         send_layer(0, 24'h000300, 1'b1);
         send_layer(-5, '0, 1'b0);
         send_layer(7, '0, 1'b1);
         send_layer(-256, 24'h000A00, 1'b0);
         send_layer(512, 24'h001400, 1'b0);
         send_layer(-768, 24'h000200, 1'b0);
         send_layer(1024, 24'h003C00, 1'b1);
         settle();
      end

      run_phase(1'b1, 0, 0, 300);
      run_phase(1'b0, 49, 0, 300);
      run_phase(1'b1, 0, 49, 300);
      run_phase(1'b0, 20, 20, 300);

      // The receiver holds off long enough for the block to back up into its input.
      configure(1'b1);
      idle_pct        = 0;
      stall_pct       = 0;
      hold_off_cycles = 400;
      send_column(MAX_LAYERS + 2, SHAPE_PROFILE);
      for (int c = 0; c < 10; c++) send_random_column();
      settle();

      configure(1'b0);
      idle_pct  = 20;
      stall_pct = 49;
      for (int c = 0; c < 40; c++) begin
         send_random_column();
         if (c % 8 == 7) wait_for_results();
      end
      settle();

      run_phase(1'b1, 49, 49, 200);

      $display("Sent %0d layer items and checked %0d results in both search directions.",
               sb.layers_seen, sb.results_seen);
      $display("Columns: %0d with a crossing, %0d unsaturated, %0d saturated.",
               sb.status_count[STATUS_CROSSING], sb.status_count[STATUS_UNSAT],
               sb.status_count[STATUS_SAT]);
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
